// ===== sv/tlwc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the toggle log window coverage block.
// No dependencies; used by the top level.
package tlwc_pkg;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic        op;
    logic [31:0] time_stamp;
    logic [31:0] window_start;
    logic [31:0] window_end;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] covered_time;
    logic        window_clamped;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH_LO,
    ST_SEARCH_HI,
    ST_READ_L,
    ST_READ_R,
    ST_DONE
  } state_t;

endpackage

// ===== sv/tlwc_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module tlwc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/toggle_log_window_coverage.sv =====
`timescale 1ns / 1ps
// Toggle log window coverage: a log of non-decreasing toggle stamps with a prefix sum of on-time,
// answering window queries. Depends on tlwc_pkg and tlwc_ram.

// A load beat gives no result; it can be accepted while a query result still
// waits on the output. A query beat with an empty log or an empty clamped
// window goes straight to the done state. Otherwise it runs two binary
// searches over the stamp memory at one read per cycle, up to
// s = ceil(log2(n+1)) steps each for n logged entries, then two reads of the
// stamp and prefix memories at the found entries. The stamp memory has a
// single read port. No new beat is accepted until the current query has
// handed its result to the output register. The memories need no clearing
// after reset.
module toggle_log_window_coverage #(
  parameter int MAX_ENTRIES = 1024,
  parameter int TIME_BITS   = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tlwc_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tlwc_pkg::out_beat_t out_data
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int TW = TIME_BITS;

  tlwc_pkg::state_t    state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [TW-1:0]       first_r, first_nxt;
  logic [TW-1:0]       last_r, last_nxt;
  logic [TW-1:0]       last_pref_r, last_pref_nxt;
  logic [TW-1:0]       key_lo_r, key_lo_nxt;
  logic [TW-1:0]       key_hi_r, key_hi_nxt;
  logic                clamp_r, clamp_nxt;
  logic [CW-1:0]       lo_r, lo_nxt;
  logic [CW-1:0]       hi_r, hi_nxt;
  logic [CW-1:0]       mid_r, mid_nxt;
  logic [CW-1:0]       il_r, il_nxt;
  logic [CW-1:0]       ir_r, ir_nxt;
  logic [TW-1:0]       part_r, part_nxt;
  logic [TW-1:0]       ans_r, ans_nxt;
  logic                out_valid_r, out_valid_nxt;
  tlwc_pkg::out_beat_t out_data_r, out_data_nxt;

  logic          wr_en;
  logic [AW-1:0] rd_addr;
  logic [TW-1:0] wr_pref;
  logic [TW-1:0] stamp_rd, pref_rd;

  // Inputs are 32 bits wide; the log works modulo 2^TIME_BITS.
  logic [TW+31:0] ts_ext, ws_ext, we_ext, ans_ext;
  logic [TW-1:0]  ts, ws, we;
  assign ts_ext  = {{TW{1'b0}}, in_data.time_stamp};
  assign ws_ext  = {{TW{1'b0}}, in_data.window_start};
  assign we_ext  = {{TW{1'b0}}, in_data.window_end};
  assign ts      = ts_ext[TW-1:0];
  assign ws      = ws_ext[TW-1:0];
  assign we      = we_ext[TW-1:0];
  assign ans_ext = {32'b0, ans_r};

  logic          in_acc;
  logic [TW-1:0] cl_lo, cl_hi;
  logic          cl_flag;
  logic [TW-1:0] key;
  logic          ge;
  logic [CW-1:0] lo_s, hi_s, mid_s;

  assign in_ready = (state_r == tlwc_pkg::ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  tlwc_ram #(.WIDTH(TW), .DEPTH(MAX_ENTRIES)) u_stamp_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (ts),
    .rd_addr (rd_addr),
    .rd_data (stamp_rd)
  );

  tlwc_ram #(.WIDTH(TW), .DEPTH(MAX_ENTRIES)) u_prefix_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (wr_pref),
    .rd_addr (rd_addr),
    .rd_data (pref_rd)
  );

  // Window clamping against the cached first and last stamps.
  always_comb begin
    cl_lo   = ws;
    cl_hi   = we;
    cl_flag = 1'b0;
    if (cl_lo < first_r) begin
      cl_lo   = first_r;
      cl_flag = 1'b1;
    end
    if (cl_lo > last_r) begin
      cl_lo   = last_r;
      cl_flag = 1'b1;
    end
    if (cl_hi < first_r) begin
      cl_hi   = first_r;
      cl_flag = 1'b1;
    end
    if (cl_hi > last_r) begin
      cl_hi   = last_r;
      cl_flag = 1'b1;
    end
  end

  // One binary search step on the stamp read back from the previous cycle.
  always_comb begin
    key   = (state_r == tlwc_pkg::ST_SEARCH_LO) ? key_lo_r : key_hi_r;
    ge    = (stamp_rd >= key);
    lo_s  = ge ? lo_r : (mid_r + CW'(1));
    hi_s  = ge ? mid_r : hi_r;
    mid_s = lo_s + ((hi_s - lo_s) >> 1);
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    first_nxt     = first_r;
    last_nxt      = last_r;
    last_pref_nxt = last_pref_r;
    key_lo_nxt    = key_lo_r;
    key_hi_nxt    = key_hi_r;
    clamp_nxt     = clamp_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    il_nxt        = il_r;
    ir_nxt        = ir_r;
    part_nxt      = part_r;
    ans_nxt       = ans_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_pref       = last_pref_r;
    rd_addr       = mid_r[AW-1:0];

    unique case (state_r)
      tlwc_pkg::ST_IDLE: begin
        if (in_acc && in_data.op == tlwc_pkg::OP_LOAD) begin
          if (count_r == '0) begin
            wr_en         = 1'b1;
            wr_pref       = '0;
            first_nxt     = ts;
            last_nxt      = ts;
            last_pref_nxt = '0;
            count_nxt     = count_r + CW'(1);
          end else if (count_r != CW'(MAX_ENTRIES) && ts >= last_r) begin
            // Segments ending at an even index are on-time.
            wr_en         = 1'b1;
            wr_pref       = count_r[0] ? last_pref_r : (last_pref_r + (ts - last_r));
            last_nxt      = ts;
            last_pref_nxt = wr_pref;
            count_nxt     = count_r + CW'(1);
          end
        end else if (in_acc) begin
          if (count_r == '0) begin
            ans_nxt   = '0;
            clamp_nxt = 1'b0;
            state_nxt = tlwc_pkg::ST_DONE;
          end else if (cl_lo > cl_hi) begin
            ans_nxt   = '0;
            clamp_nxt = cl_flag;
            state_nxt = tlwc_pkg::ST_DONE;
          end else begin
            key_lo_nxt = cl_lo;
            key_hi_nxt = cl_hi;
            clamp_nxt  = cl_flag;
            lo_nxt     = '0;
            hi_nxt     = count_r;
            mid_nxt    = count_r >> 1;
            rd_addr    = mid_nxt[AW-1:0];
            state_nxt  = tlwc_pkg::ST_SEARCH_LO;
          end
        end
      end
      tlwc_pkg::ST_SEARCH_LO: begin
        if (lo_s < hi_s) begin
          lo_nxt  = lo_s;
          hi_nxt  = hi_s;
          mid_nxt = mid_s;
          rd_addr = mid_s[AW-1:0];
        end else begin
          il_nxt    = lo_s;
          lo_nxt    = '0;
          hi_nxt    = count_r;
          mid_nxt   = count_r >> 1;
          rd_addr   = mid_nxt[AW-1:0];
          state_nxt = tlwc_pkg::ST_SEARCH_HI;
        end
      end
      tlwc_pkg::ST_SEARCH_HI: begin
        if (lo_s < hi_s) begin
          lo_nxt  = lo_s;
          hi_nxt  = hi_s;
          mid_nxt = mid_s;
          rd_addr = mid_s[AW-1:0];
        end else begin
          ir_nxt    = lo_s;
          rd_addr   = il_r[AW-1:0];
          state_nxt = tlwc_pkg::ST_READ_L;
        end
      end
      tlwc_pkg::ST_READ_L: begin
        // Partial correction at the window start, minus the prefix there.
        part_nxt  = (il_r[0] ? '0 : (stamp_rd - key_lo_r)) - pref_rd;
        rd_addr   = ir_r[AW-1:0];
        state_nxt = tlwc_pkg::ST_READ_R;
      end
      tlwc_pkg::ST_READ_R: begin
        ans_nxt   = part_r + pref_rd - (ir_r[0] ? '0 : (stamp_rd - key_hi_r));
        state_nxt = tlwc_pkg::ST_DONE;
      end
      tlwc_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.covered_time   = ans_ext[31:0];
          out_data_nxt.window_clamped = clamp_r;
          state_nxt                   = tlwc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tlwc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tlwc_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_r     <= first_nxt;
    last_r      <= last_nxt;
    last_pref_r <= last_pref_nxt;
    key_lo_r    <= key_lo_nxt;
    key_hi_r    <= key_hi_nxt;
    clamp_r     <= clamp_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    il_r        <= il_nxt;
    ir_r        <= ir_nxt;
    part_r      <= part_nxt;
    ans_r       <= ans_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ENTRIES))
    else $error("entry count beyond capacity");

  a_mid_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tlwc_pkg::ST_SEARCH_LO || state_r == tlwc_pkg::ST_SEARCH_HI)
      |-> (mid_r >= lo_r && mid_r < hi_r && hi_r <= count_r))
    else $error("search probe outside its interval");

  a_found_in_log: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tlwc_pkg::ST_READ_L) |-> (il_r < count_r && ir_r < count_r && il_r <= ir_r))
    else $error("search result outside the log");

  a_full_load_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.op == tlwc_pkg::OP_LOAD && count_r == CW'(MAX_ENTRIES))
      |=> (count_r == CW'(MAX_ENTRIES)))
    else $error("load into a full log changed the count");

  a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tlwc_pkg::ST_DONE && (!out_valid_r || out_ready))
      |=> (out_valid_r && state_r == tlwc_pkg::ST_IDLE))
    else $error("finished query did not reach the output register");

endmodule

// ===== tb/tlwc_tb_pkg.sv =====
`timescale 1ns / 1ps
// Scoreboard for the toggle log window coverage testbench: a model of the stamp log
// and its on-time prefix sums, plus the queue of expected window results.
// Depends on tlwc_pkg for the beat types and operation codes.
package tlwc_tb_pkg;
  import tlwc_pkg::*;

  localparam int LOG_DEPTH = 1024;

  class coverage_scoreboard;
    logic [31:0] stamp_log [LOG_DEPTH];
    logic [31:0] ontime_sum [LOG_DEPTH];
    int unsigned logged;
    out_beat_t   coverage_due [$];
    int unsigned mismatches;

    function new();
      logged = 0;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return coverage_due.size();
    endfunction

    // Index of the first logged stamp that is not below key, or logged if none.
    function int unsigned first_at_least(logic [31:0] key);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      lo = 0;
      hi = logged;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (stamp_log[mid] >= key) hi = mid;
        else lo = mid + 1;
      end
      return lo;
    endfunction

    function out_beat_t predict_window(logic [31:0] w_lo, logic [31:0] w_hi);
      out_beat_t   r;
      logic [31:0] span_lo;
      logic [31:0] span_hi;
      int unsigned il;
      int unsigned ir;
      r = '0;
      if (logged == 0) return r;
      span_lo = stamp_log[0];
      span_hi = stamp_log[logged - 1];
      if (w_lo < span_lo) begin w_lo = span_lo; r.window_clamped = 1'b1; end
      if (w_lo > span_hi) begin w_lo = span_hi; r.window_clamped = 1'b1; end
      if (w_hi < span_lo) begin w_hi = span_lo; r.window_clamped = 1'b1; end
      if (w_hi > span_hi) begin w_hi = span_hi; r.window_clamped = 1'b1; end
      if (w_lo <= w_hi) begin
        il = first_at_least(w_lo);
        ir = first_at_least(w_hi);
        if (il >= logged) il = logged - 1;
        if (ir >= logged) ir = logged - 1;
        // Segments ending at an even index are on-time, so the partial segment
        // in front of each found entry is added back or taken off.
        r.covered_time = ontime_sum[ir] - ontime_sum[il];
        if (il % 2 == 0) r.covered_time += stamp_log[il] - w_lo;
        if (ir % 2 == 0) r.covered_time -= stamp_log[ir] - w_hi;
      end
      return r;
    endfunction

    // Returns 1 when the beat changes the log or asks for a result.
    function bit note_input(in_beat_t b);
      logic [31:0] prev;
      if (b.op == OP_QUERY) begin
        coverage_due.push_back(predict_window(b.window_start, b.window_end));
        return 1'b1;
      end
      if (logged == LOG_DEPTH) return 1'b0;
      if (logged == 0) begin
        stamp_log[0] = b.time_stamp;
        ontime_sum[0] = '0;
      end else begin
        prev = stamp_log[logged - 1];
        if (b.time_stamp < prev) return 1'b0;
        stamp_log[logged] = b.time_stamp;
        if (logged % 2 == 0) ontime_sum[logged] = ontime_sum[logged - 1] + (b.time_stamp - prev);
        else ontime_sum[logged] = ontime_sum[logged - 1];
      end
      logged++;
      return 1'b1;
    endfunction

    function void check_result(out_beat_t r);
      out_beat_t want;
      if (coverage_due.size() == 0) begin
        $error("unexpected result: covered_time %0d, window_clamped %0b",
               r.covered_time, r.window_clamped);
        mismatches++;
        return;
      end
      want = coverage_due.pop_front();
      if (r.covered_time !== want.covered_time) begin
        $error("covered_time: expected %0d, got %0d", want.covered_time, r.covered_time);
        mismatches++;
      end
      if (r.window_clamped !== want.window_clamped) begin
        $error("window_clamped: expected %0b, got %0b", want.window_clamped, r.window_clamped);
        mismatches++;
      end
    endfunction
  endclass

endpackage

// ===== tb/tb_toggle_log_window_coverage.sv =====
`timescale 1ns / 1ps
// Testbench top for toggle_log_window_coverage: directed and random loads and window
// queries under several idling patterns, checked against the scoreboard in tlwc_tb_pkg.
// Depends on tlwc_pkg, tlwc_tb_pkg and the block's RTL.
module tb_toggle_log_window_coverage;
  import tlwc_pkg::*;
  import tlwc_tb_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned send_idle_tbl [4] = '{0, 84, 0, 15};
  int unsigned recv_stall_tbl [4] = '{0, 0, 84, 15};

  coverage_scoreboard sb = new();

  toggle_log_window_coverage i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  initial begin
    #4000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Holds the beat until it is taken; returns whether it changed the log or asked for a result.
  task automatic send_beat(input in_beat_t b, output bit did_work);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (!in_ready);
    did_work = sb.note_input(b);
  endtask

  // Always waits on a clock edge first so in_valid is not lowered and raised in one step.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic load_stamp(input logic [31:0] ts);
    in_beat_t b;
    bit       dummy;
    b.op = OP_LOAD;
    b.time_stamp = ts;
    b.window_start = $urandom;
    b.window_end = $urandom;
    send_beat(b, dummy);
  endtask

  task automatic ask_window(input logic [31:0] s, input logic [31:0] e);
    in_beat_t b;
    bit       dummy;
    b.op = OP_QUERY;
    b.time_stamp = $urandom;
    b.window_start = s;
    b.window_end = e;
    send_beat(b, dummy);
  endtask

  // Spreads the remaining log entries over the rest of the 32-bit range, so the
  // final entry lands on the all-ones stamp; some steps are zero or tiny.
  function automatic logic [31:0] next_stamp();
    longint unsigned prev;
    longint unsigned room;
    longint unsigned step;
    longint unsigned wide;
    int unsigned     left;
    prev = sb.stamp_log[sb.logged - 1];
    left = LOG_DEPTH - sb.logged;
    if (left == 1) return '1;
    room = 64'hFFFF_FFFF - prev;
    wide = $urandom;
    wide = (wide << 32) | $urandom;
    case ($urandom_range(7))
      0: step = 0;
      1: step = $urandom_range(3);
      default: step = wide % (2 * (room / left) + 1);
    endcase
    if (step > room) step = room;
    return 32'(prev + step);
  endfunction

  function automatic logic [31:0] pick_bound();
    int unsigned n;
    logic [31:0] span_lo;
    logic [31:0] span_hi;
    n = sb.logged;
    span_lo = sb.stamp_log[0];
    span_hi = sb.stamp_log[n - 1];
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return sb.stamp_log[$urandom_range(n - 1)];
      3: return sb.stamp_log[$urandom_range(n - 1)] + 32'd1;
      4: return sb.stamp_log[$urandom_range(n - 1)] - 32'd1;
      5: return $urandom_range(span_hi, span_lo);
      6: return $urandom_range(span_lo);
      default: return $urandom;
    endcase
  endfunction

  task automatic run_phase(input int unsigned goal);
    int unsigned counted;
    int unsigned load_pct;
    in_beat_t    b;
    bit          did_work;
    logic [31:0] s;
    logic [31:0] e;
    counted = 0;
    while (counted < goal) begin
      load_pct = (sb.logged < LOG_DEPTH) ? 65 : 15;
      if ($urandom_range(99) < load_pct) begin
        b.op = OP_LOAD;
        b.window_start = $urandom;
        b.window_end = $urandom;
        if (sb.logged == LOG_DEPTH) b.time_stamp = $urandom;
        else if ($urandom_range(99) < 85) b.time_stamp = next_stamp();
        else b.time_stamp = $urandom_range(sb.stamp_log[sb.logged - 1] - 32'd1);
      end else begin
        s = pick_bound();
        e = pick_bound();
        // Mostly ordered windows; the rest keep start after end.
        if (s > e && $urandom_range(3) != 0) begin
          b.window_start = e;
          b.window_end = s;
        end else begin
          b.window_start = s;
          b.window_end = e;
        end
        b.op = OP_QUERY;
        b.time_stamp = $urandom;
      end
      send_beat(b, did_work);
      if (did_work) counted++;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty log, then a single entry, then a short log with equal and stale stamps.
    ask_window(32'd0, 32'hFFFF_FFFF);
    ask_window(32'hFFFF_FFFF, 32'd0);
    load_stamp(32'd1000);
    ask_window(32'd0, 32'hFFFF_FFFF);
    ask_window(32'd1000, 32'd1000);
    load_stamp(32'd999);
    load_stamp(32'd1000);
    load_stamp(32'd1500);
    load_stamp(32'd0);
    load_stamp(32'd1800);
    load_stamp(32'd2600);
    ask_window(32'd0, 32'hFFFF_FFFF);
    ask_window(32'd1200, 32'd2000);
    ask_window(32'd2000, 32'd1200);
    ask_window(32'd0, 32'd500);
    ask_window(32'd3000, 32'hFFFF_FFFF);
    ask_window(32'd1500, 32'd1800);
    ask_window(32'd1001, 32'd1499);
    ask_window(32'hFFFF_FFFF, 32'd0);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = send_idle_tbl[p];
      recv_stall_pct = recv_stall_tbl[p];
      run_phase(500);
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
